>>> rtl/dns_name_label_encoder_assert.svh
// ----------------------------------------------------------------------------
// DNS name label encoder assertion macros
// Shared property forms for the encoder's concurrent checks.
// ----------------------------------------------------------------------------
`ifndef DNS_NAME_LABEL_ENCODER_ASSERT_SVH
`define DNS_NAME_LABEL_ENCODER_ASSERT_SVH

// same-cycle implication, disabled in reset
`define DNLE_ASSERT_IMPLY(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("dnle implication check failed");

// next-cycle implication, disabled in reset
`define DNLE_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("dnle next-cycle check failed");

// next-cycle implication, active through reset
`define DNLE_ASSERT_ALWAYS_NEXT(label, clk, ante, cons) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("dnle reset check failed");

`endif

>>> rtl/dnle_pkg.sv
// ----------------------------------------------------------------------------
// dnle_pkg
// Types and constants shared by the DNS name label encoder modules.
// ----------------------------------------------------------------------------
`default_nettype none

package dnle_pkg;

    localparam int BYTE_W  = 8;
    localparam int Q_DEPTH = 2;
    localparam int Q_PTR_W = 1;
    localparam int Q_CNT_W = 2;

    localparam logic [BYTE_W-1:0] SEP_CHAR = 8'd46;
    localparam logic [BYTE_W-1:0] END_CHAR = 8'd0;

    // one label run waiting for the back end
    typedef struct packed {
        logic              bank;
        logic [BYTE_W-1:0] len;
        logic              ovf;
        logic              name_end;
    } cmd_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_READ,
        BK_LOAD
    } bk_state_t;

endpackage

`default_nettype wire

>>> rtl/dnle_cmd_fifo.sv
// ----------------------------------------------------------------------------
// dnle_cmd_fifo
// Two-entry queue of label run commands between front and back end.
// The head entry stays until the back end finishes its run.
// ----------------------------------------------------------------------------
`default_nettype none

module dnle_cmd_fifo (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          push,
    input  dnle_pkg::cmd_t     push_cmd,
    output logic               full,
    input  wire logic          pop,
    output logic               head_valid,
    output dnle_pkg::cmd_t     head_cmd
);
    import dnle_pkg::*;

    cmd_t                entry_reg [Q_DEPTH];
    logic [Q_PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [Q_PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [Q_CNT_W-1:0]  cnt_reg, cnt_next;
    logic                do_push, do_pop;

    assign full       = (cnt_reg == Q_CNT_W'(Q_DEPTH));
    assign head_valid = (cnt_reg != '0);
    assign head_cmd   = entry_reg[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push) begin
            wr_ptr_next = wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = rd_ptr_reg + 1'b1;
        end
        unique case ({do_push, do_pop})
            2'b10:   cnt_next = cnt_reg + 1'b1;
            2'b01:   cnt_next = cnt_reg - 1'b1;
            default: cnt_next = cnt_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

`default_nettype wire

>>> rtl/dnle_front.sv
// ----------------------------------------------------------------------------
// dnle_front
// Accepts name characters, buffers label bytes into the current bank and
// queues a run command on each separator or terminator.
// ----------------------------------------------------------------------------
`default_nettype none

module dnle_front #(
    parameter int LABEL_MAX = 63,
    localparam int CNT_W    = $clog2(LABEL_MAX + 1),
    localparam int ADDR_W   = CNT_W + 1
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_valid,
    output logic                               s_ready,
    input  wire logic [dnle_pkg::BYTE_W-1:0]   s_ch,
    output logic                               wr_en,
    output logic [ADDR_W-1:0]                  wr_addr,
    output logic [dnle_pkg::BYTE_W-1:0]        wr_data,
    input  wire logic                          q_full,
    output logic                               q_push,
    output dnle_pkg::cmd_t                     q_cmd
);
    import dnle_pkg::*;

    logic [CNT_W-1:0] count_reg, count_next;
    logic             ovf_reg, ovf_next;
    logic             bank_reg, bank_next;
    logic             take, is_delim, has_room;

    assign s_ready  = !q_full;
    assign take     = s_valid && s_ready;
    assign is_delim = (s_ch == SEP_CHAR) || (s_ch == END_CHAR);
    assign has_room = (count_reg < CNT_W'(LABEL_MAX));

    assign wr_addr = {bank_reg, count_reg};
    assign wr_data = s_ch;

    always_comb begin
        count_next        = count_reg;
        ovf_next          = ovf_reg;
        bank_next         = bank_reg;
        wr_en             = 1'b0;
        q_push            = 1'b0;
        q_cmd.bank        = bank_reg;
        q_cmd.len         = BYTE_W'(count_reg);
        q_cmd.ovf         = ovf_reg;
        q_cmd.name_end    = (s_ch == END_CHAR);
        if (take) begin
            if (is_delim) begin
                q_push     = 1'b1;
                count_next = '0;
                ovf_next   = 1'b0;
                bank_next  = !bank_reg;
            end else if (has_room) begin
                wr_en      = 1'b1;
                count_next = count_reg + 1'b1;
            end else begin
                ovf_next   = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
            ovf_reg   <= 1'b0;
            bank_reg  <= 1'b0;
        end else begin
            count_reg <= count_next;
            ovf_reg   <= ovf_next;
            bank_reg  <= bank_next;
        end
    end

endmodule

`default_nettype wire

>>> rtl/dnle_back.sv
// ----------------------------------------------------------------------------
// dnle_back
// Holds the two-bank label memory and plays out each queued run: the
// length byte, then the label bytes, through a registered output stage.
// ----------------------------------------------------------------------------
`default_nettype none

module dnle_back #(
    parameter int LABEL_MAX = 63,
    localparam int CNT_W    = $clog2(LABEL_MAX + 1),
    localparam int ADDR_W   = CNT_W + 1,
    localparam int DEPTH    = 2 ** ADDR_W
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          wr_en,
    input  wire logic [ADDR_W-1:0]             wr_addr,
    input  wire logic [dnle_pkg::BYTE_W-1:0]   wr_data,
    input  wire logic                          q_valid,
    input  dnle_pkg::cmd_t                     q_cmd,
    output logic                               q_pop,
    output logic                               m_valid,
    input  wire logic                          m_ready,
    output logic [dnle_pkg::BYTE_W-1:0]        m_out_byte,
    output logic                               m_run_last,
    output logic                               m_name_end,
    output logic                               m_label_overflow
);
    import dnle_pkg::*;

    logic [BYTE_W-1:0] mem [DEPTH];
    logic [BYTE_W-1:0] rd_data_reg;
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;

    bk_state_t         state_reg, state_next;
    logic [CNT_W-1:0]  idx_reg, idx_next;

    logic              m_valid_reg;
    logic [BYTE_W-1:0] byte_reg;
    logic              last_reg, end_reg, ovf_reg;

    logic              out_free, load, load_last, idx_last;
    logic [BYTE_W-1:0] load_byte;

    assign out_free = !m_valid_reg || m_ready;
    assign rd_addr  = {q_cmd.bank, idx_reg};
    assign idx_last = ((BYTE_W'(idx_reg) + BYTE_W'(1)) == q_cmd.len);

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_comb begin
        state_next = state_reg;
        idx_next   = idx_reg;
        q_pop      = 1'b0;
        rd_en      = 1'b0;
        load       = 1'b0;
        load_byte  = q_cmd.len;
        load_last  = 1'b0;
        unique case (state_reg)
            BK_IDLE: begin
                if (q_valid && out_free) begin
                    load      = 1'b1;
                    load_byte = q_cmd.len;
                    load_last = (q_cmd.len == '0);
                    idx_next  = '0;
                    if (q_cmd.len == '0) begin
                        q_pop = 1'b1;
                    end else begin
                        state_next = BK_READ;
                    end
                end
            end
            BK_READ: begin
                rd_en      = 1'b1;
                state_next = BK_LOAD;
            end
            BK_LOAD: begin
                if (out_free) begin
                    load      = 1'b1;
                    load_byte = rd_data_reg;
                    load_last = idx_last;
                    if (idx_last) begin
                        q_pop      = 1'b1;
                        state_next = BK_IDLE;
                    end else begin
                        idx_next   = idx_reg + 1'b1;
                        state_next = BK_READ;
                    end
                end
            end
            default: state_next = BK_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= BK_IDLE;
            idx_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            if (load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            byte_reg <= load_byte;
            last_reg <= load_last;
            end_reg  <= load_last && q_cmd.name_end;
            ovf_reg  <= q_cmd.ovf;
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_out_byte       = byte_reg;
    assign m_run_last       = last_reg;
    assign m_name_end       = end_reg;
    assign m_label_overflow = ovf_reg;

endmodule

`default_nettype wire

>>> rtl/dns_name_label_encoder.sv
// Flow: a separator or terminator is queued in the command FIFO, and its length byte
//   is loaded into the output register once the back end is idle and the output free.
// Throughput: 1 label character per cycle while the command queue is not full; each
//   label byte is a memory read, then an output register load in the back end.
// Reset: synchronous, active low; clears control state, label memory is not cleared.
// ----------------------------------------------------------------------------
// dns_name_label_encoder
// Dotted name to DNS wire label encoder: front end buffers labels into a
// two-bank memory, back end emits length byte and label bytes per run.
// ----------------------------------------------------------------------------
`default_nettype none

module dns_name_label_encoder #(
    parameter int LABEL_MAX = 63
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_valid,
    output logic                               s_ready,
    input  wire logic [dnle_pkg::BYTE_W-1:0]   s_ch,
    output logic                               m_valid,
    input  wire logic                          m_ready,
    output logic [dnle_pkg::BYTE_W-1:0]        m_out_byte,
    output logic                               m_run_last,
    output logic                               m_name_end,
    output logic                               m_label_overflow
);
    import dnle_pkg::*;

    localparam int CNT_W  = $clog2(LABEL_MAX + 1);
    localparam int ADDR_W = CNT_W + 1;

    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [BYTE_W-1:0] wr_data;
    logic              q_full, q_push, q_pop, q_valid;
    cmd_t              push_cmd, head_cmd;

    dnle_front #(
        .LABEL_MAX (LABEL_MAX)
    ) u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_ch    (s_ch),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .q_full  (q_full),
        .q_push  (q_push),
        .q_cmd   (push_cmd)
    );

    dnle_cmd_fifo u_fifo (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (q_push),
        .push_cmd   (push_cmd),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (q_valid),
        .head_cmd   (head_cmd)
    );

    dnle_back #(
        .LABEL_MAX (LABEL_MAX)
    ) u_back (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .wr_en            (wr_en),
        .wr_addr          (wr_addr),
        .wr_data          (wr_data),
        .q_valid          (q_valid),
        .q_cmd            (head_cmd),
        .q_pop            (q_pop),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_out_byte       (m_out_byte),
        .m_run_last       (m_run_last),
        .m_name_end       (m_name_end),
        .m_label_overflow (m_label_overflow)
    );

endmodule

`default_nettype wire

>>> rtl/dnle_checker.sv
// ----------------------------------------------------------------------------
// dnle_checker
// Port-level checks on the encoder's result channel, bound to the top.
// ----------------------------------------------------------------------------
`default_nettype none

`include "dns_name_label_encoder_assert.svh"

module dnle_checker (
    input wire logic                          aclk,
    input wire logic                          aresetn,
    input wire logic                          m_valid,
    input wire logic                          m_ready,
    input wire logic [dnle_pkg::BYTE_W-1:0]   m_out_byte,
    input wire logic                          m_run_last,
    input wire logic                          m_name_end,
    input wire logic                          m_label_overflow
);
    import dnle_pkg::*;

    logic              held;
    logic [BYTE_W+2:0] payload;

    assign held    = m_valid && !m_ready;
    assign payload = {m_out_byte, m_run_last, m_name_end, m_label_overflow};

    `DNLE_ASSERT_NEXT(a_stall_valid, aclk, aresetn, held, m_valid)
    `DNLE_ASSERT_NEXT(a_stall_data, aclk, aresetn, held, $stable(payload))
    `DNLE_ASSERT_IMPLY(a_end_is_last, aclk, aresetn, m_valid && m_name_end, m_run_last)
    `DNLE_ASSERT_ALWAYS_NEXT(a_reset_clears, aclk, !aresetn, !m_valid)

endmodule

bind dns_name_label_encoder dnle_checker u_dnle_checker (
    .aclk             (aclk),
    .aresetn          (aresetn),
    .m_valid          (m_valid),
    .m_ready          (m_ready),
    .m_out_byte       (m_out_byte),
    .m_run_last       (m_run_last),
    .m_name_end       (m_name_end),
    .m_label_overflow (m_label_overflow)
);

`default_nettype wire

>>> sim/dns_name_label_encoder_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dns_name_label_encoder_tb
// Drives dotted names into the label encoder one character per transfer and
// compares every wire byte against a software label builder. Directed names
// hit empty labels, doubled and trailing dots and the extreme character
// codes. Random names cover short, medium and over-length labels, with some
// noise. Both sides stall in random bursts, and the receiver once holds off
// long enough to back the encoder up.
// ----------------------------------------------------------------------------

module dns_name_label_encoder_tb;

    localparam int LABEL_MAX    = 63;
    localparam int CHAR_TARGET  = 500;
    localparam int CALM_AFTER   = 420;
    localparam int HOLD_AT      = 200;
    localparam int HOLD_CYCLES  = 300;
    localparam int STALL_LIMIT  = 4000;
    localparam int DRAIN_CYCLES = 40;

    typedef struct packed {
        logic [7:0] wire_byte;
        logic       run_last;
        logic       name_end;
        logic       label_ovf;
    } wire_item_t;

    // builds the expected wire bytes from the characters the encoder took
    class wire_label_model;
        int unsigned cap;
        logic [7:0]  lab_buf[];
        int unsigned lab_len;
        bit          lab_trunc;
        wire_item_t  due[$];
        int          n_chars, n_runs, n_trunc, n_checked, n_errors;

        function new(int unsigned label_cap);
            cap       = label_cap;
            lab_buf   = new[label_cap];
            lab_len   = 0;
            lab_trunc = 1'b0;
            n_chars   = 0;
            n_runs    = 0;
            n_trunc   = 0;
            n_checked = 0;
            n_errors  = 0;
        endfunction

        function void take_char(logic [7:0] c);
            wire_item_t it;
            bit at_end;
            n_chars++;
            if (c != dnle_pkg::SEP_CHAR && c != dnle_pkg::END_CHAR) begin
                if (lab_len < cap) begin
                    lab_buf[lab_len] = c;
                    lab_len++;
                end else begin
                    lab_trunc = 1'b1;
                end
                return;
            end
            at_end       = (c == dnle_pkg::END_CHAR);
            it.wire_byte = 8'(lab_len);
            it.run_last  = (lab_len == 0);
            it.name_end  = at_end && (lab_len == 0);
            it.label_ovf = lab_trunc;
            due.push_back(it);
            for (int i = 0; i < lab_len; i++) begin
                it.wire_byte = lab_buf[i];
                it.run_last  = (i == lab_len - 1);
                it.name_end  = at_end && (i == lab_len - 1);
                it.label_ovf = lab_trunc;
                due.push_back(it);
            end
            n_runs++;
            if (lab_trunc)
                n_trunc++;
            lab_len   = 0;
            lab_trunc = 1'b0;
        endfunction

        function void field_check(string field, logic [7:0] want, logic [7:0] got);
            if (got !== want) begin
                $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
                n_errors++;
            end
        endfunction

        function void match_wire_byte(logic [7:0] b, logic last, logic fin, logic ovf);
            wire_item_t want;
            if (due.size() == 0) begin
                $display("%0t: unexpected wire byte, expected none, actual %0d", $time, b);
                n_errors++;
                return;
            end
            want = due.pop_front();
            n_checked++;
            field_check("out_byte", want.wire_byte, b);
            field_check("run_last", 8'(want.run_last), 8'(last));
            field_check("name_end", 8'(want.name_end), 8'(fin));
            field_check("label_overflow", 8'(want.label_ovf), 8'(ovf));
        endfunction

        function int pending();
            return due.size();
        endfunction
    endclass

    logic       aclk    = 1'b0;
    logic       aresetn = 1'b0;
    logic       s_valid = 1'b0;
    logic       s_ready;
    logic [7:0] s_ch    = 8'd0;
    logic       m_valid;
    logic       m_ready = 1'b0;
    logic [7:0] m_out_byte;
    logic       m_run_last;
    logic       m_name_end;
    logic       m_label_overflow;

    wire_label_model labels = new(LABEL_MAX);

    bit idle_on       = 1'b1;
    bit long_hold_req = 1'b0;
    int sent          = 0;
    int forced_lens[$];

    always #2 aclk = ~aclk;

    dns_name_label_encoder #(
        .LABEL_MAX(LABEL_MAX)
    ) u_dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_ch            (s_ch),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_out_byte      (m_out_byte),
        .m_run_last      (m_run_last),
        .m_name_end      (m_name_end),
        .m_label_overflow(m_label_overflow)
    );

    // result side: random ready bursts plus one long hold-off
    initial begin
        int stall_left;
        int hold_left;
        stall_left = 0;
        hold_left  = 0;
        forever begin
            @(posedge aclk);
            if (long_hold_req) begin
                long_hold_req = 1'b0;
                hold_left     = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                m_ready <= 1'b0;
            end else if (idle_on && $urandom_range(0, 3) == 0) begin
                stall_left = $urandom_range(1, 7) - 1;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            labels.match_wire_byte(m_out_byte, m_run_last, m_name_end, m_label_overflow);
    end

    initial begin : watchdog
        int stall_cycles;
        stall_cycles = 0;
        while (stall_cycles < STALL_LIMIT) begin
            @(posedge aclk);
            if ((s_valid && s_ready) || (m_valid && m_ready))
                stall_cycles = 0;
            else
                stall_cycles++;
        end
        $display("dns_name_label_encoder_tb: errors");
        $finish;
    end

    task automatic send_char(input logic [7:0] c);
        int gap;
        if (idle_on && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 7);
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_ch    <= c;
        do @(posedge aclk); while (!s_ready);
        labels.take_char(c);
        sent++;
        if (sent == HOLD_AT)
            long_hold_req = 1'b1;
        if (sent == CALM_AFTER)
            idle_on = 1'b0;
    endtask

    function automatic logic [7:0] rand_label_char();
        logic [7:0] c;
        do c = 8'($urandom_range(1, 255)); while (c == dnle_pkg::SEP_CHAR);
        return c;
    endfunction

    function automatic int pick_label_len();
        int r;
        r = $urandom_range(0, 99);
        if (forced_lens.size() != 0)
            return forced_lens.pop_front();
        if (r < 80)
            return $urandom_range(0, 8);
        if (r < 95)
            return $urandom_range(9, 40);
        return $urandom_range(60, 72);
    endfunction

    task automatic send_name();
        int n_labels;
        int len;
        n_labels = $urandom_range(1, 4);
        for (int l = 0; l < n_labels; l++) begin
            len = pick_label_len();
            for (int k = 0; k < len; k++)
                send_char(rand_label_char());
            if (l != n_labels - 1 || $urandom_range(0, 7) == 0)
                send_char(dnle_pkg::SEP_CHAR);
            if ($urandom_range(0, 9) == 0)
                send_char(dnle_pkg::SEP_CHAR);
        end
        send_char(dnle_pkg::END_CHAR);
    endtask

    task automatic send_noise();
        int n;
        n = $urandom_range(1, 6);
        repeat (n) begin
            case ($urandom_range(0, 3))
                0:       send_char(dnle_pkg::END_CHAR);
                1:       send_char(dnle_pkg::SEP_CHAR);
                default: send_char(8'($urandom_range(0, 255)));
            endcase
        end
    endtask

    initial begin
        logic [7:0] directed[$];
        directed = '{
            dnle_pkg::END_CHAR,                                        // bare root
            dnle_pkg::SEP_CHAR,                                        // leading dot
            8'h01, 8'hFF, dnle_pkg::SEP_CHAR,
            8'h61, dnle_pkg::SEP_CHAR, dnle_pkg::SEP_CHAR,             // doubled dot
            8'h78, dnle_pkg::SEP_CHAR, dnle_pkg::END_CHAR,             // trailing dot
            8'd45, 8'd47, 8'h80, 8'h7F, dnle_pkg::END_CHAR,
            8'h7A, dnle_pkg::END_CHAR
        };
        // exactly full, one over, well over
        forced_lens = '{LABEL_MAX, LABEL_MAX + 1, LABEL_MAX + 9};

        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (directed[i])
            send_char(directed[i]);
        while (sent < CHAR_TARGET) begin
            if ($urandom_range(0, 7) == 0)
                send_noise();
            else
                send_name();
        end
        // close any open label so every buffered byte comes out
        send_char(dnle_pkg::END_CHAR);
        s_valid <= 1'b0;

        while (labels.pending() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("covered %0d characters, %0d label runs (%0d truncated), %0d wire bytes",
                 labels.n_chars, labels.n_runs, labels.n_trunc, labels.n_checked);
        $display("receiver held off %0d cycles once; random stalls on both sides",
                 HOLD_CYCLES);
        if (labels.n_errors == 0)
            $display("dns_name_label_encoder_tb: clean");
        else
            $display("dns_name_label_encoder_tb: errors");
        $finish;
    end

endmodule

>>> filelist.f
+incdir+rtl
rtl/dnle_pkg.sv
rtl/dnle_cmd_fifo.sv
rtl/dnle_front.sv
rtl/dnle_back.sv
rtl/dns_name_label_encoder.sv
rtl/dnle_checker.sv
sim/dns_name_label_encoder_tb.sv
